@@ hdl/ac_status_frame_deframer_unit_defines.svh @@
// ----------------------------------------------------------------------------
// ac_status_frame_deframer_unit_defines
// Assertion macros used by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef AC_STATUS_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define AC_STATUS_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// checked only outside reset
`define ACSFD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: check failed");

// checked at every edge, reset included
`define ACSFD_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("%m: check failed");

`endif

@@ hdl/acsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// acsfd_pkg
// Types, constants and code tables of the status frame deframer.
// ----------------------------------------------------------------------------
package acsfd_pkg;

  localparam int MAX_FRAME  = 64;
  localparam int POS_W      = $clog2(MAX_FRAME + 1);
  localparam int TOT_W      = 9;
  localparam int LEN_W      = 7;
  localparam int CAP_N      = 8;
  localparam int HDR_TRAIL  = 6;
  localparam int LEN_POS    = 4;
  localparam int SHORT_LEN  = 8;
  localparam int OUT_W      = 46;
  localparam int TDATA_W    = ((OUT_W + 7) / 8) * 8;

  // frame length must exceed these to carry the named bytes
  localparam int LEN_SENSOR = 19;
  localparam int LEN_QUIET  = 33;
  localparam int LEN_GENTLE = 50;
  localparam int LEN_LOUVER = 52;

  localparam logic [7:0] SYNC_BYTE   = 8'hBB;
  localparam logic [7:0] MODE_MASK   = 8'h3F;
  localparam logic [7:0] MODE_FORCE  = 8'h20;
  localparam logic [7:0] TARGET_MASK = 8'h0F;
  localparam logic [7:0] QUIET_MASK  = 8'h80;
  localparam logic [7:0] FAN_MASK    = 8'hF0;
  localparam logic [4:0] TARGET_BASE = 5'd16;
  localparam logic [4:0] TARGET_RST  = 5'd24;

  localparam int SLOT_POS [CAP_N] = '{7, 8, 17, 18, 33, 50, 51, 52};

  typedef enum logic [1:0] {
    FS_GOOD    = 2'd0,
    FS_BAD_SUM = 2'd1,
    FS_SHORT   = 2'd2
  } frame_status_e;

  typedef enum logic [2:0] {
    MODE_OFF       = 3'd0,
    MODE_HEAT_COOL = 3'd1,
    MODE_COOL      = 3'd2,
    MODE_DRY       = 3'd3,
    MODE_FAN_ONLY  = 3'd4,
    MODE_HEAT      = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    FAN_AUTO    = 3'd0,
    FAN_LOW     = 3'd1,
    FAN_MEDIUM  = 3'd2,
    FAN_MIDDLE  = 3'd3,
    FAN_FOCUS   = 3'd4,
    FAN_HIGH    = 3'd5,
    FAN_QUIET   = 3'd6,
    FAN_DIFFUSE = 3'd7
  } fan_e;

  localparam logic [7:0] MCODE_HEAT_COOL = 8'h35;
  localparam logic [7:0] MCODE_COOL      = 8'h31;
  localparam logic [7:0] MCODE_DRY       = 8'h33;
  localparam logic [7:0] MCODE_FAN_ONLY  = 8'h32;
  localparam logic [7:0] MCODE_HEAT      = 8'h34;

  localparam logic [7:0] FCODE_LOW    = 8'h90;
  localparam logic [7:0] FCODE_MEDIUM = 8'hA0;
  localparam logic [7:0] FCODE_MIDDLE = 8'hC0;
  localparam logic [7:0] FCODE_FOCUS  = 8'hB0;
  localparam logic [7:0] FCODE_HIGH   = 8'hD0;

  typedef logic [CAP_N-1:0][7:0] cap_t;

  typedef struct packed {
    logic [3:0]  horiz;
    logic [3:0]  vert;
    logic        gentle;
    logic [15:0] raw;
    logic [4:0]  target;
    fan_e        fan;
    mode_e       mode;
  } status_t;

  typedef struct packed {
    logic [3:0]       horiz;
    logic [3:0]       vert;
    logic             gentle;
    logic [15:0]      raw;
    logic [4:0]       target;
    fan_e             fan;
    mode_e            mode;
    logic             power;
    logic [LEN_W-1:0] length;
    frame_status_e    status;
  } result_t;

  function automatic logic [3:0] vert_code(input logic [7:0] c);
    logic [3:0] r;
    unique case (c)
      8'h01:   r = 4'd4;
      8'h02:   r = 4'd5;
      8'h03:   r = 4'd6;
      8'h04:   r = 4'd7;
      8'h05:   r = 4'd8;
      8'h08:   r = 4'd1;
      8'h10:   r = 4'd2;
      8'h18:   r = 4'd3;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] horiz_code(input logic [7:0] c);
    logic [3:0] r;
    unique case (c)
      8'h01:   r = 4'd5;
      8'h02:   r = 4'd6;
      8'h03:   r = 4'd7;
      8'h04:   r = 4'd8;
      8'h05:   r = 4'd9;
      8'h08:   r = 4'd1;
      8'h10:   r = 4'd2;
      8'h18:   r = 4'd3;
      8'h20:   r = 4'd4;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/acsfd_decode.sv @@
// ----------------------------------------------------------------------------
// acsfd_decode
// Turns the captured bytes of a good frame into the updated unit status.
// ----------------------------------------------------------------------------
module acsfd_decode (
  input  acsfd_pkg::cap_t                  cap_i,
  input  logic [acsfd_pkg::POS_W-1:0]      len_i,
  input  acsfd_pkg::status_t               prev_i,
  output acsfd_pkg::status_t               next_o
);

  logic [7:0] b7;
  logic [7:0] b8;
  logic [7:0] mcode;

  assign b7    = cap_i[0];
  assign b8    = cap_i[1];
  assign mcode = (b7 & acsfd_pkg::MODE_MASK) | acsfd_pkg::MODE_FORCE;

  always_comb begin
    next_o = prev_i;
    if (len_i > acsfd_pkg::POS_W'(acsfd_pkg::LEN_SENSOR)) begin
      next_o.target = 5'(b8 & acsfd_pkg::TARGET_MASK) + acsfd_pkg::TARGET_BASE;
      next_o.raw    = {cap_i[2], cap_i[3]};
    end
    if (!b7[4]) begin
      next_o.mode = acsfd_pkg::MODE_OFF;
    end else begin
      unique case (mcode)
        acsfd_pkg::MCODE_COOL:     next_o.mode = acsfd_pkg::MODE_COOL;
        acsfd_pkg::MCODE_DRY:      next_o.mode = acsfd_pkg::MODE_DRY;
        acsfd_pkg::MCODE_FAN_ONLY: next_o.mode = acsfd_pkg::MODE_FAN_ONLY;
        acsfd_pkg::MCODE_HEAT:     next_o.mode = acsfd_pkg::MODE_HEAT;
        default:                   next_o.mode = acsfd_pkg::MODE_HEAT_COOL;
      endcase
      if (len_i > acsfd_pkg::POS_W'(acsfd_pkg::LEN_QUIET) &&
          (cap_i[4] & acsfd_pkg::QUIET_MASK) != '0) begin
        next_o.fan = acsfd_pkg::FAN_QUIET;
      end else if ((b7 & acsfd_pkg::QUIET_MASK) != '0) begin
        next_o.fan = acsfd_pkg::FAN_DIFFUSE;
      end else begin
        unique case (b8 & acsfd_pkg::FAN_MASK)
          acsfd_pkg::FCODE_LOW:    next_o.fan = acsfd_pkg::FAN_LOW;
          acsfd_pkg::FCODE_MEDIUM: next_o.fan = acsfd_pkg::FAN_MEDIUM;
          acsfd_pkg::FCODE_MIDDLE: next_o.fan = acsfd_pkg::FAN_MIDDLE;
          acsfd_pkg::FCODE_FOCUS:  next_o.fan = acsfd_pkg::FAN_FOCUS;
          acsfd_pkg::FCODE_HIGH:   next_o.fan = acsfd_pkg::FAN_HIGH;
          default:                 next_o.fan = acsfd_pkg::FAN_AUTO;
        endcase
      end
    end
    if (len_i > acsfd_pkg::POS_W'(acsfd_pkg::LEN_GENTLE)) begin
      next_o.gentle = cap_i[5][5];
    end
    if (len_i > acsfd_pkg::POS_W'(acsfd_pkg::LEN_LOUVER)) begin
      next_o.vert  = acsfd_pkg::vert_code(cap_i[6]);
      next_o.horiz = acsfd_pkg::horiz_code(cap_i[7]);
    end
  end

endmodule

@@ hdl/ac_status_frame_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// ac_status_frame_deframer_unit
// Deframes status frames from a byte stream and reports the decoded status.
// ----------------------------------------------------------------------------
// Takes one received byte per clock. A byte is accepted whenever the result
// register is empty or being drained, so a stream runs at one byte per cycle.
// The frame position, checksum and captured bytes update in the cycle a byte
// is accepted; the result for a frame is registered into the output register
// when its final byte is accepted and holds until taken. Oversized frames and
// bytes between frames produce no result.
module ac_status_frame_deframer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,   // [7:0] rx_byte
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // frame_status, frame_length, unit_power, run_mode, fan_setting,
  // target_celsius, raw_sensor, gentle_wind, vertical_louver,
  // horizontal_louver, zero fill
  output logic [acsfd_pkg::TDATA_W-1:0]   m_axis_tdata_o
);

  localparam int PW = acsfd_pkg::POS_W;
  localparam int TW = acsfd_pkg::TOT_W;

  logic [PW-1:0]       pos_q, pos_d;
  logic [PW-1:0]       exp_q, exp_d;
  logic [7:0]          xor_q, xor_d;
  acsfd_pkg::cap_t     cap_q, cap_d;
  acsfd_pkg::status_t  cur_q, cur_d, dec;
  acsfd_pkg::result_t  out_q, out_d;
  logic                m_valid_q, m_valid_d;

  logic                acc;
  logic                hunting;
  logic [PW-1:0]       pos_inc;
  logic [TW-1:0]       tot;
  logic                too_long;
  logic                done;
  logic [7:0]          xor_n;
  logic [7:0]          rx;

  assign rx              = s_axis_tdata_i;
  assign s_axis_tready_o = !m_valid_q || m_axis_tready_i;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign hunting         = (pos_q == '0);
  assign pos_inc         = pos_q + PW'(1);
  assign tot             = TW'(rx) + TW'(acsfd_pkg::HDR_TRAIL);
  assign too_long        = tot > TW'(acsfd_pkg::MAX_FRAME);
  assign xor_n           = xor_q ^ rx;
  assign done            = !hunting && (exp_q != '0) && (pos_inc >= exp_q);

  always_comb begin
    for (int k = 0; k < acsfd_pkg::CAP_N; k++) begin
      cap_d[k] = (pos_q == PW'(acsfd_pkg::SLOT_POS[k])) ? rx : cap_q[k];
    end
  end

  acsfd_decode u_decode (
    .cap_i  (cap_d),
    .len_i  (exp_q),
    .prev_i (cur_q),
    .next_o (dec)
  );

  always_comb begin
    pos_d     = pos_q;
    exp_d     = exp_q;
    xor_d     = xor_q;
    cur_d     = cur_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    out_d     = out_q;
    out_d.status = acsfd_pkg::FS_GOOD;
    if (exp_q < PW'(acsfd_pkg::SHORT_LEN)) begin
      out_d.status = acsfd_pkg::FS_SHORT;
    end else if (xor_n != '0) begin
      out_d.status = acsfd_pkg::FS_BAD_SUM;
    end else begin
      cur_d = dec;
    end
    out_d.length = acsfd_pkg::LEN_W'(exp_q);
    out_d.power  = (cur_d.mode != acsfd_pkg::MODE_OFF);
    out_d.mode   = cur_d.mode;
    out_d.fan    = cur_d.fan;
    out_d.target = cur_d.target;
    out_d.raw    = cur_d.raw;
    out_d.gentle = cur_d.gentle;
    out_d.vert   = cur_d.vert;
    out_d.horiz  = cur_d.horiz;
    if (!(acc && done)) begin
      cur_d = cur_q;
    end
    if (acc) begin
      if (hunting) begin
        if (rx == acsfd_pkg::SYNC_BYTE) begin
          pos_d = PW'(1);
          xor_d = rx;
        end
      end else if (pos_q == PW'(acsfd_pkg::LEN_POS) && too_long) begin
        pos_d = '0;
        exp_d = '0;
        xor_d = '0;
      end else if (done) begin
        pos_d     = '0;
        exp_d     = '0;
        xor_d     = '0;
        m_valid_d = 1'b1;
      end else begin
        pos_d = pos_inc;
        xor_d = xor_n;
        if (pos_q == PW'(acsfd_pkg::LEN_POS)) begin
          exp_d = PW'(tot);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      exp_q        <= '0;
      xor_q        <= '0;
      m_valid_q    <= 1'b0;
      cur_q.mode   <= acsfd_pkg::MODE_OFF;
      cur_q.fan    <= acsfd_pkg::FAN_AUTO;
      cur_q.target <= acsfd_pkg::TARGET_RST;
      cur_q.raw    <= '0;
      cur_q.gentle <= 1'b0;
      cur_q.vert   <= '0;
      cur_q.horiz  <= '0;
    end else begin
      pos_q     <= pos_d;
      exp_q     <= exp_d;
      xor_q     <= xor_d;
      m_valid_q <= m_valid_d;
      cur_q     <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      cap_q <= cap_d;
    end
    if (acc && done) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(acsfd_pkg::TDATA_W - acsfd_pkg::OUT_W)'(0), out_q};

endmodule

@@ hdl/acsfd_checker.sv @@
// ----------------------------------------------------------------------------
// acsfd_checker
// Port-level checks on the status frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "ac_status_frame_deframer_unit_defines.svh"

module acsfd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [acsfd_pkg::TDATA_W-1:0] m_axis_tdata_o
);

  `ACSFD_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
  `ACSFD_ASSERT(a_ready_when_empty, !m_axis_tvalid_o |-> s_axis_tready_o)
  `ACSFD_ASSERT(a_result_sane, m_axis_tvalid_o |-> m_axis_tdata_o[1:0] != 2'd3 && m_axis_tdata_o[8:2] >= 7'd6 && m_axis_tdata_o[8:2] <= 7'(acsfd_pkg::MAX_FRAME))
  `ACSFD_ASSERT(a_result_needs_request, m_axis_tvalid_o && !$past(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o))
  `ACSFD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !m_axis_tvalid_o)

endmodule

bind ac_status_frame_deframer_unit acsfd_checker u_acsfd_checker (.*);
